[rtl/stack_calculator_assert.svh]
// Assertion macros used by the stack calculator datapath.
// Depends on the asserting module naming its clock i_clk and its reset i_rst_n.
`ifndef STACK_CALCULATOR_ASSERT_SVH
`define STACK_CALCULATOR_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define SC_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define SC_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/sc_pkg.sv]
// Package for the stack calculator: sizes, operation and status codes,
// controller states and the controller/datapath command and status structs.
// No dependencies.
package sc_pkg;

    localparam int STACK_DEPTH = 128;
    localparam int DATA_W      = 32;
    localparam int OP_W        = 3;
    localparam int STATUS_W    = 3;
    localparam int DEPTH_OUT_W = 8;
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W      = $clog2(STACK_DEPTH);

    typedef enum logic [OP_W-1:0] {
        OP_PUSH = 3'd0,
        OP_POP  = 3'd1,
        OP_ADD  = 3'd2,
        OP_SUB  = 3'd3,
        OP_MUL  = 3'd4,
        OP_DIV  = 3'd5
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_UNDERFLOW = 3'd1,
        ST_OVERFLOW  = 3'd2,
        ST_DIVZERO   = 3'd3,
        ST_INVALID   = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        CNT_HOLD,
        CNT_INC,
        CNT_DEC,
        CNT_DEC2
    } t_cnt_op;

    typedef enum logic {
        RD_TOP,
        RD_SECOND
    } t_rd_sel;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_POP_RD,
        S_RD_B,
        S_RD_A,
        S_EXEC,
        S_DIV,
        S_WRITE,
        S_FINISH
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic    in_ready;
        logic    load_in;
        logic    rd_en;
        t_rd_sel rd_sel;
        logic    push_wr;
        logic    res_wr;
        t_cnt_op cnt_op;
        logic    cap_b;
        logic    cap_a;
        logic    exec_arith;
        logic    div_start;
        logic    div_cap;
        logic    res_from_rd;
        logic    set_status;
        t_status status;
        logic    out_load;
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic            in_valid;
        logic [OP_W-1:0] op;
        logic            cnt_zero;
        logic            cnt_lt2;
        logic            cnt_full;
        logic            b_zero;
        logic            div_done;
        logic            out_free;
    } t_dp_stat;

endpackage

[rtl/sc_if.sv]
// Valid/ready channel interfaces for the stack calculator command input
// and result output. Depends on sc_pkg.
interface sc_in_if;
    import sc_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [OP_W-1:0]          operation;
    logic signed [DATA_W-1:0] push_value;

    modport source (output valid, output operation, output push_value, input ready);
    modport sink   (input valid, input operation, input push_value, output ready);
endinterface

interface sc_out_if;
    import sc_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [STATUS_W-1:0]      status;
    logic signed [DATA_W-1:0] result_value;
    logic [DEPTH_OUT_W-1:0]   stack_depth;

    modport source (output valid, output status, output result_value, output stack_depth,
                    input ready);
    modport sink   (input valid, input status, input result_value, input stack_depth,
                    output ready);
endinterface

[rtl/sc_divider.sv]
// Signed truncating divider, one quotient bit per cycle (restoring).
// Depends on sc_pkg. Divisor must be nonzero; caller checks that.
module sc_divider (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [sc_pkg::DATA_W-1:0] i_dividend,
    input  logic [sc_pkg::DATA_W-1:0] i_divisor,
    output logic                      o_done,
    output logic [sc_pkg::DATA_W-1:0] o_quotient
);
    import sc_pkg::*;

    localparam int ITER_W = $clog2(DATA_W);

    logic              r_busy;
    logic              r_done;
    logic [ITER_W-1:0] r_iter;
    logic [DATA_W-1:0] r_rem;
    logic [DATA_W-1:0] r_quo;
    logic [DATA_W-1:0] r_dvs;
    logic              r_neg;

    logic [DATA_W-1:0] w_abs_a;
    logic [DATA_W-1:0] w_abs_b;
    logic [DATA_W:0]   w_shift;
    logic [DATA_W:0]   w_trial;

    // Magnitudes; the most negative value maps to 2^31 unsigned
    assign w_abs_a = i_dividend[DATA_W-1] ? (~i_dividend + 1'b1) : i_dividend;
    assign w_abs_b = i_divisor[DATA_W-1]  ? (~i_divisor + 1'b1)  : i_divisor;

    // One restoring step; remainder stays below the divisor, so 32 bits hold it
    assign w_shift = {r_rem, r_quo[DATA_W-1]};
    assign w_trial = w_shift - {1'b0, r_dvs};

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_iter <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_iter <= '0;
            end else if (r_busy) begin
                r_iter <= r_iter + 1'b1;
                if (r_iter == ITER_W'(DATA_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= w_abs_a;
            r_dvs <= w_abs_b;
            r_neg <= i_dividend[DATA_W-1] ^ i_divisor[DATA_W-1];
        end else if (r_busy) begin
            if (!w_trial[DATA_W]) begin
                r_rem <= w_trial[DATA_W-1:0];
                r_quo <= {r_quo[DATA_W-2:0], 1'b1};
            end else begin
                r_rem <= w_shift[DATA_W-1:0];
                r_quo <= {r_quo[DATA_W-2:0], 1'b0};
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_neg ? (~r_quo + 1'b1) : r_quo;

endmodule

[rtl/sc_datapath.sv]
// Stack calculator datapath: stack memory, entry count, operand and result
// registers, ALU, divider and the output register. Depends on sc_pkg,
// sc_if, sc_divider and stack_calculator_assert.svh.
`include "stack_calculator_assert.svh"

module sc_datapath (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  sc_pkg::t_dp_cmd  i_cmd,
    output sc_pkg::t_dp_stat o_stat,
    sc_in_if.sink            i_in,
    sc_out_if.source         o_out
);
    import sc_pkg::*;

    logic [DATA_W-1:0] r_mem [STACK_DEPTH];

    logic [CNT_W-1:0]       r_count;
    logic [CNT_W-1:0]       n_count;
    logic [OP_W-1:0]        r_op;
    logic [DATA_W-1:0]      r_val;
    logic [DATA_W-1:0]      r_rd;
    logic [DATA_W-1:0]      r_a;
    logic [DATA_W-1:0]      r_b;
    logic [DATA_W-1:0]      r_res;
    logic [STATUS_W-1:0]    r_status;
    logic                   r_out_valid;
    logic [STATUS_W-1:0]    r_out_status;
    logic [DATA_W-1:0]      r_out_res;
    logic [DEPTH_OUT_W-1:0] r_out_depth;

    logic [CNT_W-1:0]  w_cnt_m1;
    logic [CNT_W-1:0]  w_cnt_m2;
    logic [ADDR_W-1:0] w_rd_addr;
    logic              w_wr_en;
    logic [ADDR_W-1:0] w_wr_addr;
    logic [DATA_W-1:0] w_wr_data;
    logic [DATA_W-1:0] w_alu;
    logic [DATA_W-1:0] w_prod;
    logic              w_div_done;
    logic [DATA_W-1:0] w_quo;
    logic              w_out_free;

    assign w_cnt_m1 = r_count - CNT_W'(1);
    assign w_cnt_m2 = r_count - CNT_W'(2);

    // Input beat capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_op  <= i_in.operation;
            r_val <= i_in.push_value;
        end
    end

    // Entry count
    always_comb begin
        case (i_cmd.cnt_op)
            CNT_INC:  n_count = r_count + CNT_W'(1);
            CNT_DEC:  n_count = w_cnt_m1;
            CNT_DEC2: n_count = w_cnt_m2;
            default:  n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    // Stack memory: one write port, one registered read port
    assign w_rd_addr = (i_cmd.rd_sel == RD_TOP) ? w_cnt_m1[ADDR_W-1:0] : w_cnt_m2[ADDR_W-1:0];
    assign w_wr_en   = i_cmd.push_wr | i_cmd.res_wr;
    assign w_wr_addr = i_cmd.push_wr ? r_count[ADDR_W-1:0] : w_cnt_m2[ADDR_W-1:0];
    assign w_wr_data = i_cmd.push_wr ? r_val : r_res;

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[w_wr_addr] <= w_wr_data;
        end
        if (i_cmd.rd_en) begin
            r_rd <= r_mem[w_rd_addr];
        end
    end

    // Operands
    always_ff @(posedge i_clk) begin
        if (i_cmd.cap_b) begin
            r_b <= r_rd;
        end
        if (i_cmd.cap_a) begin
            r_a <= r_rd;
        end
    end

    // ALU: add, subtract, low half of the product
    assign w_prod = r_a * r_b;

    always_comb begin
        case (r_op)
            OP_ADD:  w_alu = r_a + r_b;
            OP_SUB:  w_alu = r_a - r_b;
            default: w_alu = w_prod;
        endcase
    end

    sc_divider u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (r_a),
        .i_divisor  (r_b),
        .o_done     (w_div_done),
        .o_quotient (w_quo)
    );

    // Result and status of the command in flight
    always_ff @(posedge i_clk) begin
        if (i_cmd.set_status) begin
            r_status <= i_cmd.status;
            r_res    <= '0;
        end else if (i_cmd.res_from_rd) begin
            r_res <= r_rd;
        end else if (i_cmd.exec_arith) begin
            r_res <= w_alu;
        end else if (i_cmd.div_cap) begin
            r_res <= w_quo;
        end
    end

    // Output register
    assign w_out_free = !r_out_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_status <= r_status;
            r_out_res    <= r_res;
            r_out_depth  <= DEPTH_OUT_W'(r_count);
        end
    end

    // Ports
    assign i_in.ready         = i_cmd.in_ready;
    assign o_out.valid        = r_out_valid;
    assign o_out.status       = r_out_status;
    assign o_out.result_value = r_out_res;
    assign o_out.stack_depth  = r_out_depth;

    // Status to controller
    always_comb begin
        o_stat          = '0;
        o_stat.in_valid = i_in.valid;
        o_stat.op       = r_op;
        o_stat.cnt_zero = (r_count == '0);
        o_stat.cnt_lt2  = (r_count < CNT_W'(2));
        o_stat.cnt_full = (r_count >= CNT_W'(STACK_DEPTH));
        o_stat.b_zero   = (r_b == '0);
        o_stat.div_done = w_div_done;
        o_stat.out_free = w_out_free;
    end

    // Checks
    `SC_ASSERT_IMP(a_cnt_bound, 1'b1, r_count <= CNT_W'(STACK_DEPTH), "entry count past depth")
    `SC_ASSERT_IMP(a_push_room, i_cmd.push_wr, r_count < CNT_W'(STACK_DEPTH), "push onto full stack")
    `SC_ASSERT_IMP(a_out_free, i_cmd.out_load, w_out_free, "result overwrote pending beat")
    `SC_ASSERT_IMP(a_err_zero, r_out_valid && r_out_status != ST_OK, r_out_res == '0,
                   "error beat with nonzero value")
    `SC_ASSERT_NXT(a_cnt_inc, i_cmd.cnt_op == CNT_INC, r_count == $past(r_count) + CNT_W'(1),
                   "count did not step up")

endmodule

[rtl/sc_controller.sv]
// Stack calculator controller: sequences one command at a time through
// decode, stack reads, execute, write-back and result hand-off. Depends on sc_pkg.
module sc_controller (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  sc_pkg::t_dp_stat i_stat,
    output sc_pkg::t_dp_cmd  o_cmd
);
    import sc_pkg::*;

    t_state r_state;
    t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.in_ready = 1'b1;
                if (i_stat.in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = S_DECODE;
                end
            end
            S_DECODE: begin
                o_cmd.set_status = 1'b1;
                o_cmd.status     = ST_OK;
                unique case (i_stat.op) inside
                    OP_PUSH: begin
                        if (i_stat.cnt_full) begin
                            o_cmd.status = ST_OVERFLOW;
                        end else begin
                            o_cmd.push_wr = 1'b1;
                            o_cmd.cnt_op  = CNT_INC;
                        end
                        n_state = S_FINISH;
                    end
                    OP_POP: begin
                        if (i_stat.cnt_zero) begin
                            o_cmd.status = ST_UNDERFLOW;
                            n_state      = S_FINISH;
                        end else begin
                            o_cmd.rd_en  = 1'b1;
                            o_cmd.rd_sel = RD_TOP;
                            o_cmd.cnt_op = CNT_DEC;
                            n_state      = S_POP_RD;
                        end
                    end
                    OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
                        if (i_stat.cnt_lt2) begin
                            o_cmd.status = ST_UNDERFLOW;
                            n_state      = S_FINISH;
                        end else begin
                            o_cmd.rd_en  = 1'b1;
                            o_cmd.rd_sel = RD_TOP;
                            n_state      = S_RD_B;
                        end
                    end
                    default: begin
                        o_cmd.status = ST_INVALID;
                        n_state      = S_FINISH;
                    end
                endcase
            end
            S_POP_RD: begin
                o_cmd.res_from_rd = 1'b1;
                n_state           = S_FINISH;
            end
            S_RD_B: begin
                o_cmd.cap_b  = 1'b1;
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = RD_SECOND;
                n_state      = S_RD_A;
            end
            S_RD_A: begin
                o_cmd.cap_a = 1'b1;
                n_state     = S_EXEC;
            end
            S_EXEC: begin
                if (i_stat.op == OP_DIV) begin
                    if (i_stat.b_zero) begin
                        o_cmd.set_status = 1'b1;
                        o_cmd.status     = ST_DIVZERO;
                        o_cmd.cnt_op     = CNT_DEC2;
                        n_state          = S_FINISH;
                    end else begin
                        o_cmd.div_start = 1'b1;
                        n_state         = S_DIV;
                    end
                end else begin
                    o_cmd.exec_arith = 1'b1;
                    n_state          = S_WRITE;
                end
            end
            S_DIV: begin
                if (i_stat.div_done) begin
                    o_cmd.div_cap = 1'b1;
                    n_state       = S_WRITE;
                end
            end
            S_WRITE: begin
                // two operands off, result on: net one entry fewer
                o_cmd.res_wr = 1'b1;
                o_cmd.cnt_op = CNT_DEC;
                n_state      = S_FINISH;
            end
            S_FINISH: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

[rtl/stack_calculator.sv]
// Stack calculator over 32-bit signed integers: each command beat pushes,
// pops, or combines the two top entries by add, subtract, multiply or
// truncating divide, and yields exactly one result beat carrying a status,
// a value and the new depth. Commands are handled one at a time; a
// divide runs through the restoring divider, one quotient bit per cycle.
// The result sits in an output register, so the next command is accepted
// while a result still waits; a completed command then holds until that
// result is taken. Depends on sc_pkg, sc_if, sc_controller and sc_datapath.
module stack_calculator (
    input  logic     i_clk,
    input  logic     i_rst_n,
    sc_in_if.sink    i_in,
    sc_out_if.source o_out
);
    import sc_pkg::*;

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    sc_controller u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd)
    );

    sc_datapath u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .o_stat  (w_stat),
        .i_in    (i_in),
        .o_out   (o_out)
    );

endmodule
